/* src/ppc_pkg.sv */
package ppc_pkg;

  // defaults for the top-level parameters
  localparam int PPC_CORDIC_STAGES = 16;
  localparam int PPC_COORD_WIDTH   = 16;

  // field and register widths
  localparam int FIELD_W  = 16;
  localparam int GAIN_W   = 12;
  localparam int STOP_W   = 16;
  localparam int STOPSQ_W = 2 * STOP_W;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // angle accumulator in 1/2^20 rad, bearing in 1/4096 rad
  localparam int ZW         = 24;
  localparam int BW         = ZW - 8;
  localparam int ATAN_LEN   = 24;
  localparam int HALF_PI_Z  = 1647099;
  localparam int ROUND_HALF = 128;

  localparam int LIN_MAX = 65535;
  localparam int ANG_MAX = 32767;
  localparam int ANG_MIN = -32768;

  // register indexes
  localparam logic [1:0] REG_GAIN_DIST = 2'd0;
  localparam logic [1:0] REG_GAIN_BEAR = 2'd1;
  localparam logic [1:0] REG_STOP_DIST = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_DIST_RST = 12'd128;
  localparam logic [GAIN_W-1:0] GAIN_BEAR_RST = 12'd179;
  localparam logic [STOP_W-1:0] STOP_DIST_RST = 16'd410;

  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
    24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
    24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
    24'sd256,    24'sd128,    24'sd64,     24'sd32,
    24'sd16,     24'sd8,      24'sd4,      24'sd2,
    24'sd1,      24'sd0,      24'sd0,      24'sd0
  };

  typedef struct packed {
    logic signed [FIELD_W-1:0] offset_x;
    logic signed [FIELD_W-1:0] offset_y;
  } ppc_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]        linear_velocity;
    logic signed [FIELD_W-1:0] angular_velocity;
    logic                      stopped;
  } ppc_out_t;

  // per-stage control carried along the pipe
  typedef struct packed {
    logic valid;
    logic stopped;
    logic zero;
  } ppc_flags_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_distance;
    logic [GAIN_W-1:0]   gain_bearing;
    logic [STOPSQ_W-1:0] stop_sq;
  } ppc_cfg_t;

endpackage

/* src/ppc_regs.sv */
module ppc_regs import ppc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output ppc_cfg_t          cfg
);

  logic [GAIN_W-1:0]   gain_dist_r;
  logic [GAIN_W-1:0]   gain_bear_r;
  logic [STOP_W-1:0]   stop_dist_r;
  logic [STOPSQ_W-1:0] stop_sq_r;
  logic [1:0]          idx;
  logic                wr;

  assign idx = paddr[APB_AW-1:2];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_dist_r <= GAIN_DIST_RST;
      gain_bear_r <= GAIN_BEAR_RST;
      stop_dist_r <= STOP_DIST_RST;
      stop_sq_r   <= STOPSQ_W'(STOP_DIST_RST) * STOPSQ_W'(STOP_DIST_RST);
    end else begin
      if (wr) begin
        case (idx)
          REG_GAIN_DIST: gain_dist_r <= pwdata[GAIN_W-1:0];
          REG_GAIN_BEAR: gain_bear_r <= pwdata[GAIN_W-1:0];
          REG_STOP_DIST: stop_dist_r <= pwdata[STOP_W-1:0];
          default: ;
        endcase
      end
      // squared threshold is registered from the stop distance register and follows it in the next cycle
      stop_sq_r <= STOPSQ_W'(stop_dist_r) * STOPSQ_W'(stop_dist_r);
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_DIST: prdata = APB_DW'(gain_dist_r);
      REG_GAIN_BEAR: prdata = APB_DW'(gain_bear_r);
      REG_STOP_DIST: prdata = APB_DW'(stop_dist_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.gain_distance = gain_dist_r;
  assign cfg.gain_bearing  = gain_bear_r;
  assign cfg.stop_sq       = stop_sq_r;

endmodule

/* src/ppc_cell.sv */
module ppc_cell import ppc_pkg::*; #(
  parameter int W       = PPC_COORD_WIDTH,
  parameter int SHIFT   = 0,
  parameter bit DO_ROOT = 1'b1,
  parameter bit DO_ROT  = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ppc_flags_t            flags_i,
  input  logic signed [W+1:0]   x_i,
  input  logic signed [W+1:0]   y_i,
  input  logic signed [ZW-1:0]  z_i,
  input  logic [2*W-1:0]        n_i,
  input  logic [W+1:0]          rem_i,
  input  logic [W-1:0]          root_i,
  output ppc_flags_t            flags_o,
  output logic signed [W+1:0]   x_o,
  output logic signed [W+1:0]   y_o,
  output logic signed [ZW-1:0]  z_o,
  output logic [2*W-1:0]        n_o,
  output logic [W+1:0]          rem_o,
  output logic [W-1:0]          root_o
);

  localparam int XW  = W + 2;
  localparam int SQW = 2 * W;
  localparam int RW  = W + 2;

  ppc_flags_t            flags_r;
  logic signed [XW-1:0]  x_r, x_nxt;
  logic signed [XW-1:0]  y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic [SQW-1:0]        n_r, n_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [W-1:0]          root_r, root_nxt;

  logic [RW-1:0]         rem_sh;
  logic [RW-1:0]         trial;
  logic                  ge;
  logic signed [XW-1:0]  xs, ys;

  // one root digit: bring down two bits of the square, try 4*root+1
  assign rem_sh = {rem_i[RW-3:0], n_i[SQW-1 -: 2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  always_comb begin
    if (DO_ROOT) begin
      n_nxt    = {n_i[SQW-3:0], 2'b00};
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_i[W-2:0], ge};
    end else begin
      n_nxt    = n_i;
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end

    if (DO_ROT) begin
      // rotate toward the x axis, steered by the sign of y
      if (!y_i[XW-1]) begin
        x_nxt = x_i + ys;
        y_nxt = y_i - xs;
        z_nxt = z_i + ATAN_TAB[SHIFT];
      end else begin
        x_nxt = x_i - ys;
        y_nxt = y_i + xs;
        z_nxt = z_i - ATAN_TAB[SHIFT];
      end
    end else begin
      x_nxt = x_i;
      y_nxt = y_i;
      z_nxt = z_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r <= flags_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      n_r    <= n_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign flags_o = flags_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign n_o     = n_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;

endmodule

/* src/polar_proportional_chase_controller_unit.sv */
// Polar proportional chase controller.
// Input channel (in_valid / in_stall / in_data): one target offset (offset_x,
// offset_y) per item, signed, 1/1024 m. Output channel (out_valid / out_stall
// / out_data): one command per item, linear speed, turn rate and a stopped
// flag, in the order the items came in.
// Configuration: APB-style port at cfg_*, gain_distance at 0x0, gain_bearing
// at 0x4, stop_distance at 0x8. Write only while no item is in flight.
// The pipe length is set by the cell chain: each cell resolves one bit of
// the integer square root, runs one CORDIC vectoring iteration, or both,
// so the longer of the two sets the number of cells.
// Throughput: one item per cycle while the receiver does not stall; every stage is a register stage.
// When the receiver stalls, the output register holds its item; the pipe
// keeps moving to fill empty stages and only stalls the input once the item
// behind the output register is valid.
// Reset (rst_n low, synchronous) empties the pipe and restores the register
// defaults; no clearing pass follows.
module polar_proportional_chase_controller_unit import ppc_pkg::*; #(
  parameter int CORDIC_STAGES = PPC_CORDIC_STAGES,
  parameter int COORD_WIDTH   = PPC_COORD_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ppc_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ppc_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int W     = COORD_WIDTH;
  localparam int XW    = W + 2;
  localparam int SQW   = 2 * W;
  localparam int RW    = W + 2;
  localparam int CW    = (SQW > STOPSQ_W) ? SQW : STOPSQ_W;
  localparam int CSTG  = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int NCELL = (W > CSTG) ? W : CSTG;
  localparam int LPW   = GAIN_W + W + 1;
  localparam int APW   = GAIN_W + 1 + BW;

  ppc_cfg_t cfg;

  ppc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // pipe control
  logic       pipe_en;
  logic       out_load;
  ppc_flags_t p2_flags_r;
  logic       out_valid_r;

  assign out_load = !out_valid_r || !out_stall;
  assign pipe_en  = out_load || !p2_flags_r.valid;
  assign in_stall = !pipe_en;

  // stage 1: coordinates and magnitudes
  logic signed [W-1:0] cx_in, cy_in;
  logic signed [W-1:0] s1_x_r, s1_y_r;
  logic [W-1:0]        s1_ax_r, s1_ay_r;
  logic                s1_valid_r;

  assign cx_in = W'($unsigned(in_data.offset_x));
  assign cy_in = W'($unsigned(in_data.offset_y));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_x_r  <= cx_in;
      s1_y_r  <= cy_in;
      s1_ax_r <= cx_in[W-1] ? W'(-cx_in) : W'(cx_in);
      s1_ay_r <= cy_in[W-1] ? W'(-cy_in) : W'(cy_in);
    end
  end

  // stage 2: squares, quarter turn into the right half plane
  logic [SQW-1:0]        s2_sqx_r, s2_sqy_r;
  logic signed [XW-1:0]  s2_x_r, s2_y_r, s2_x_nxt, s2_y_nxt;
  logic signed [ZW-1:0]  s2_z_r, s2_z_nxt;
  logic signed [XW-1:0]  xe, ye;
  logic                  s2_valid_r, s2_zero_r;

  assign xe = XW'(s1_x_r);
  assign ye = XW'(s1_y_r);

  always_comb begin
    if (s1_x_r[W-1]) begin
      if (!s1_y_r[W-1]) begin
        s2_x_nxt = ye;
        s2_y_nxt = -xe;
        s2_z_nxt = ZW'(HALF_PI_Z);
      end else begin
        s2_x_nxt = -ye;
        s2_y_nxt = xe;
        s2_z_nxt = -ZW'(HALF_PI_Z);
      end
    end else begin
      s2_x_nxt = xe;
      s2_y_nxt = ye;
      s2_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_sqx_r  <= SQW'(s1_ax_r) * SQW'(s1_ax_r);
      s2_sqy_r  <= SQW'(s1_ay_r) * SQW'(s1_ay_r);
      s2_x_r    <= s2_x_nxt;
      s2_y_r    <= s2_y_nxt;
      s2_z_r    <= s2_z_nxt;
      s2_zero_r <= (s1_x_r == '0) && (s1_y_r == '0);
    end
  end

  // stage 3: sum of squares and stop test
  logic [SQW-1:0]       s3_sq_r, s3_sq_nxt;
  logic signed [XW-1:0] s3_x_r, s3_y_r;
  logic signed [ZW-1:0] s3_z_r;
  ppc_flags_t           s3_flags_r;

  assign s3_sq_nxt = s2_sqx_r + s2_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_flags_r <= '0;
    end else if (pipe_en) begin
      s3_flags_r.valid   <= s2_valid_r;
      s3_flags_r.stopped <= CW'(s3_sq_nxt) < CW'(cfg.stop_sq);
      s3_flags_r.zero    <= s2_zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_sq_r <= s3_sq_nxt;
      s3_x_r  <= s2_x_r;
      s3_y_r  <= s2_y_r;
      s3_z_r  <= s2_z_r;
    end
  end

  // cell chain: root digits and CORDIC iterations
  ppc_flags_t           c_flags [NCELL+1];
  logic signed [XW-1:0] c_x     [NCELL+1];
  logic signed [XW-1:0] c_y     [NCELL+1];
  logic signed [ZW-1:0] c_z     [NCELL+1];
  logic [SQW-1:0]       c_n     [NCELL+1];
  logic [RW-1:0]        c_rem   [NCELL+1];
  logic [W-1:0]         c_root  [NCELL+1];

  assign c_flags[0] = s3_flags_r;
  assign c_x[0]     = s3_x_r;
  assign c_y[0]     = s3_y_r;
  assign c_z[0]     = s3_z_r;
  assign c_n[0]     = s3_sq_r;
  assign c_rem[0]   = '0;
  assign c_root[0]  = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ppc_cell #(
      .W       (W),
      .SHIFT   ((i < CSTG) ? i : 0),
      .DO_ROOT (i < W),
      .DO_ROT  (i < CSTG)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .flags_i (c_flags[i]),
      .x_i     (c_x[i]),
      .y_i     (c_y[i]),
      .z_i     (c_z[i]),
      .n_i     (c_n[i]),
      .rem_i   (c_rem[i]),
      .root_i  (c_root[i]),
      .flags_o (c_flags[i+1]),
      .x_o     (c_x[i+1]),
      .y_o     (c_y[i+1]),
      .z_o     (c_z[i+1]),
      .n_o     (c_n[i+1]),
      .rem_o   (c_rem[i+1]),
      .root_o  (c_root[i+1])
    );
  end

  // post 1: bearing rounding, linear product
  logic signed [ZW-1:0]  z_rnd;
  logic signed [BW-1:0]  p1_bear_r;
  logic [GAIN_W+W-1:0]   p1_lin_prod_r;
  ppc_flags_t            p1_flags_r;

  assign z_rnd = (c_z[NCELL] + ZW'(ROUND_HALF)) >>> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_flags_r <= '0;
    end else if (pipe_en) begin
      p1_flags_r <= c_flags[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_bear_r     <= c_flags[NCELL].zero ? '0 : z_rnd[BW-1:0];
      p1_lin_prod_r <= (GAIN_W+W)'(cfg.gain_distance) * (GAIN_W+W)'(c_root[NCELL]);
    end
  end

  // post 2: linear rounding and clamp, angular product
  logic [LPW-1:0]          lin_q;
  logic [FIELD_W-1:0]      p2_lin_r;
  logic signed [APW-1:0]   p2_ang_prod_r;

  assign lin_q = ({1'b0, p1_lin_prod_r} + LPW'(ROUND_HALF)) >> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_flags_r <= '0;
    end else if (pipe_en) begin
      p2_flags_r <= p1_flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p2_lin_r      <= (lin_q > LPW'(LIN_MAX)) ? FIELD_W'(LIN_MAX) : lin_q[FIELD_W-1:0];
      p2_ang_prod_r <= $signed({1'b0, cfg.gain_bearing}) * p1_bear_r;
    end
  end

  // output register: angular rounding and clamp
  logic signed [APW:0] ang_q;
  logic signed [FIELD_W-1:0] ang_sat;
  ppc_out_t out_data_r;

  assign ang_q = ($signed({p2_ang_prod_r[APW-1], p2_ang_prod_r}) + (APW+1)'(ROUND_HALF)) >>> 8;

  always_comb begin
    if (ang_q > (APW+1)'(ANG_MAX)) begin
      ang_sat = FIELD_W'(ANG_MAX);
    end else if (ang_q < (APW+1)'(ANG_MIN)) begin
      ang_sat = FIELD_W'(ANG_MIN);
    end else begin
      ang_sat = ang_q[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= p2_flags_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.stopped <= p2_flags_r.stopped;
      if (p2_flags_r.stopped) begin
        out_data_r.linear_velocity  <= '0;
        out_data_r.angular_velocity <= '0;
      end else begin
        out_data_r.linear_velocity  <= p2_lin_r;
        out_data_r.angular_velocity <= ang_sat;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/ppc_checker.sv */
module ppc_checker import ppc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ppc_out_t out_data
);

  // a held item stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // a stop command carries no motion
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stopped |->
      out_data.linear_velocity == '0 && out_data.angular_velocity == '0)
    else $error("stopped item with nonzero command");

  // input is only held back by a stalled output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind polar_proportional_chase_controller_unit ppc_checker u_ppc_checker (.*);
